>>> rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and codes of the cartridge bank mapper
// State and result records passed between the core and its decoder.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Read sources
    localparam logic [1:0] TGT_UNMAPPED = 2'd0;
    localparam logic [1:0] TGT_SUBSLOT  = 2'd1;
    localparam logic [1:0] TGT_SOUND    = 2'd2;
    localparam logic [1:0] TGT_FLASH    = 2'd3;

    // Mapper modes, mode register bits 7..5
    localparam logic [2:0] MAP_SOUND_8K = 3'd0;
    localparam logic [2:0] MAP_SPLIT_8K = 3'd1;
    localparam logic [2:0] MAP_DIRECT_A = 3'd2;
    localparam logic [2:0] MAP_DIRECT_B = 3'd3;
    localparam logic [2:0] MAP_WIN_2K_A = 3'd4;
    localparam logic [2:0] MAP_WIN_2K_B = 3'd5;
    localparam logic [2:0] MAP_PAIR_A   = 3'd6;
    localparam logic [2:0] MAP_PAIR_B   = 3'd7;

    typedef struct packed {
        logic [7:0]       mode;
        logic [6:0]       offset;
        logic [7:0]       subslot;
        logic [15:0][7:0] banks;
        logic [7:0]       snd_mode;
        logic [3:0][7:0]  snd_banks;
    } cbm_state_t;

    typedef struct packed {
        logic [1:0]  read_target;
        logic [7:0]  local_data;
        logic [19:0] flash_addr;
        logic        flash_write;
        logic [7:0]  sound_addr;
        logic        sound_write;
        logic        sound_mode_write;
        logic        sound_plus_mode;
    } cbm_result_t;

endpackage

>>> rtl/core/cbm_decode.sv
// ----------------------------------------------------------------------------
// cbm_decode: access decoder of the cartridge bank mapper
// Routes one access, forms the flash address and works out the next state.
// ----------------------------------------------------------------------------
module cbm_decode
(
    input  cbm_pkg::cbm_state_t  state_cur,
    input  logic                 req_type,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    output cbm_pkg::cbm_state_t  state_next,
    output cbm_pkg::cbm_result_t result
);

    localparam logic [15:0] ADDR_SUBSLOT  = 16'hFFFF;
    localparam logic [14:0] ADDR_MODE     = 15'h3FFF;   // 0x7FFE and 0x7FFF
    localparam logic [14:0] ADDR_SND_MODE = 15'h5FFF;   // 0xBFFE and 0xBFFF
    localparam logic [4:0]  WIN_COMPAT    = 5'b10011;   // 0x9800 to 0x9FFF
    localparam logic [4:0]  WIN_EXTEND    = 5'b10111;   // 0xB800 to 0xBFFF

    function automatic logic [1:0] subslot_of(logic [7:0] mode, logic [7:0] sel,
                                              logic [1:0] page);
        logic [2:0] pos;
        pos = {page, 1'b0};
        subslot_of = mode[4] ? sel[pos +: 2] : 2'd0;
    endfunction

    // The compatible window opens via the third sound bank, the extended one via the fourth.
    function automatic logic [1:0] sound_enable(logic [7:0] smode, logic [3:0][7:0] sbanks);
        if (smode[5] && sbanks[3][7])
            sound_enable = 2'd2;
        else if (!smode[5] && (sbanks[2][5:0] == 6'h3F))
            sound_enable = 2'd1;
        else
            sound_enable = 2'd0;
    endfunction

    always_comb
    begin
        cbm_pkg::cbm_state_t nxt;
        cbm_pkg::cbm_result_t res;
        logic [1:0]  page;
        logic [2:0]  p_wide;
        logic [1:0]  p;
        logic        p_ok;
        logic        big;
        logic [1:0]  s_old;
        logic [1:0]  s_new;
        logic [3:0]  idx;
        logic [8:0]  bsum;
        logic [19:0] t;
        logic [19:0] pre_fa;
        logic [1:0]  en;
        logic        win1;
        logic        win2;
        logic        ram2;
        logic        ram3;
        logic [7:0]  mask;
        logic [7:0]  v2;
        logic [7:0]  v2p1;

        nxt  = state_cur;
        res  = '0;
        page = address[15:14];
        p_wide = address[15:13] - 3'd2;
        p    = p_wide[1:0];
        p_ok = (page == 2'b01) || (page == 2'b10);
        win1 = address[15:11] == WIN_COMPAT;
        win2 = address[15:11] == WIN_EXTEND;
        v2   = {write_data[6:0], 1'b0};
        v2p1 = {write_data[6:0], 1'b1};

        // Flash address from the state as it stands before any update.
        big   = state_cur.mode[7:6] == 2'b01;
        s_old = subslot_of(state_cur.mode, state_cur.subslot, page);
        idx   = big ? {s_old, page} : {s_old, p};
        bsum  = {1'b0, state_cur.banks[idx]} + {2'b00, state_cur.offset};
        if (big)
            t = {bsum[5:0], address[13:0]};
        else
            t = {bsum[6:0], address[12:0]};
        if (big || p_ok)
            pre_fa = {s_old, 18'd0} + t;
        else
            pre_fa = '0;

        en   = 2'd0;
        ram2 = 1'b0;
        ram3 = 1'b0;
        mask = 8'h7F;
        s_new = 2'd0;

        if (req_type == cbm_pkg::REQ_READ)
        begin
            en = sound_enable(state_cur.snd_mode, state_cur.snd_banks);
            if (state_cur.mode[4] && (address == ADDR_SUBSLOT))
            begin
                res.read_target = cbm_pkg::TGT_SUBSLOT;
                res.local_data  = ~state_cur.subslot;
            end
            else if ((state_cur.mode[7:5] == cbm_pkg::MAP_SOUND_8K) &&
                     (((en == 2'd1) && win1) || ((en == 2'd2) && win2)))
            begin
                res.read_target = cbm_pkg::TGT_SOUND;
                res.sound_addr  = address[7:0];
            end
            else if (big || p_ok)
            begin
                res.read_target = cbm_pkg::TGT_FLASH;
                res.flash_addr  = pre_fa;
            end
            else
            begin
                res.read_target = cbm_pkg::TGT_UNMAPPED;
                res.local_data  = 8'hFF;
            end
        end
        else
        begin
            if (state_cur.mode[4] && (address == ADDR_SUBSLOT))
                nxt.subslot = write_data;
            if (!state_cur.mode[2] && (address[15:1] == ADDR_MODE))
                nxt.mode = write_data;

            // Everything below sees the mode and subslot just written.
            if (nxt.mode[7:5] == cbm_pkg::MAP_SOUND_8K)
            begin
                if (address[15:1] == ADDR_SND_MODE)
                begin
                    nxt.snd_mode = write_data;
                    res.sound_mode_write = 1'b1;
                end
                en   = sound_enable(nxt.snd_mode, state_cur.snd_banks);
                ram3 = nxt.snd_mode[4];
                ram2 = (nxt.snd_mode[5] && nxt.snd_mode[2]) || ram3;
                if (((en == 2'd1) && !ram2 && win1) || ((en == 2'd2) && !ram3 && win2))
                begin
                    res.sound_write = 1'b1;
                    res.sound_addr  = address[7:0];
                end
            end

            s_new = subslot_of(nxt.mode, nxt.subslot, page);
            if (!nxt.mode[1] && p_ok)
            begin
                unique case (nxt.mode[7:5]) inside
                    cbm_pkg::MAP_SOUND_8K:
                    begin
                        if (address[12:11] == 2'b10)
                        begin
                            nxt.snd_banks[p] = write_data;
                            if (write_data[7] && (p == 2'd0))
                                nxt.offset = write_data[6:0];
                            else
                            begin
                                mask = nxt.mode[0] ? 8'h3F : 8'h7F;
                                nxt.banks[{s_new, p}] = write_data & mask;
                            end
                        end
                    end
                    cbm_pkg::MAP_SPLIT_8K:
                    begin
                        // Only 0x5000-0x57FF and 0x6000 upwards, or the latter alone.
                        mask = nxt.mode[0] ? 8'h1F : 8'h7F;
                        if (!(nxt.mode[3] && (address < 16'h6000)) &&
                            !(address < 16'h5000) &&
                            !((address >= 16'h5800) && (address < 16'h6000)))
                            nxt.banks[{s_new, p}] = write_data & mask;
                    end
                    cbm_pkg::MAP_DIRECT_A, cbm_pkg::MAP_DIRECT_B:
                    begin
                        nxt.banks[{s_new, p}] = write_data;
                    end
                    cbm_pkg::MAP_WIN_2K_A, cbm_pkg::MAP_WIN_2K_B:
                    begin
                        if (address[15:13] == 3'b011)
                            nxt.banks[{s_new, address[12:11]}] = write_data;
                    end
                    cbm_pkg::MAP_PAIR_A, cbm_pkg::MAP_PAIR_B:
                    begin
                        if (address[15:11] == 5'b01100)
                        begin
                            nxt.banks[{s_new, 2'd0}] = v2;
                            nxt.banks[{s_new, 2'd1}] = v2p1;
                        end
                        if (address[15:11] == 5'b01110)
                        begin
                            nxt.banks[{s_new, 2'd2}] = v2;
                            nxt.banks[{s_new, 2'd3}] = v2p1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if ((nxt.mode[7:6] == 2'b01) || p_ok)
            begin
                res.flash_write = 1'b1;
                res.flash_addr  = pre_fa;
            end
        end

        res.sound_plus_mode = nxt.snd_mode[5];
        state_next = nxt;
        result     = res;
    end

endmodule

>>> rtl/core/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core: bank mapper for an 8-bit-bus cartridge
// Decodes bus accesses, keeps the mapper registers and reports flash and
// sound-chip traffic.
// ----------------------------------------------------------------------------
// The block takes one bus access item per clock cycle while the response side
// does not stall, and returns one result item for each: the item is captured in
// an input register, decoded in a single pass against the mapper registers, and
// the result lands in an output register while the registers update at the same
// edge. The output register lets a new item enter while a finished result is
// still held by a stall. All mapper state lives in flip-flops and is cleared by
// reset, so the block is ready as soon as reset is released.
module cartridge_bank_mapper_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  read_target,
    output logic [7:0]  local_data,
    output logic [19:0] flash_addr,
    output logic        flash_write,
    output logic [7:0]  sound_addr,
    output logic        sound_write,
    output logic        sound_mode_write,
    output logic        sound_plus_mode
);

    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic                 in_type_reg;
    logic [15:0]          in_addr_reg;
    logic [7:0]           in_data_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    cbm_pkg::cbm_result_t out_reg;
    cbm_pkg::cbm_state_t  state_reg;
    cbm_pkg::cbm_state_t  state_next;
    cbm_pkg::cbm_result_t result;
    logic                 accept;
    logic                 advance;

    assign advance   = in_vld_reg && (!out_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (!rsp_stall)
            out_vld_next = 1'b0;
    end

    cbm_decode u_decode
    (
        .state_cur  (state_reg),
        .req_type   (in_type_reg),
        .address    (in_addr_reg),
        .write_data (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_type_reg <= req_type;
            in_addr_reg <= address;
            in_data_reg <= write_data;
        end
        if (advance)
            out_reg <= result;
    end

    assign rsp_valid        = out_vld_reg;
    assign read_target      = out_reg.read_target;
    assign local_data       = out_reg.local_data;
    assign flash_addr       = out_reg.flash_addr;
    assign flash_write      = out_reg.flash_write;
    assign sound_addr       = out_reg.sound_addr;
    assign sound_write      = out_reg.sound_write;
    assign sound_mode_write = out_reg.sound_mode_write;
    assign sound_plus_mode  = out_reg.sound_plus_mode;

endmodule

>>> bench/cartridge_bank_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core_tb: self-checking bench for the bank mapper core
// Sends bus accesses with random gaps and keeps its own copy of the mapper
// registers to predict every result item. The response side stalls at random
// and compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core_tb;

    typedef enum logic [1:0] {WIN_OFF, WIN_COMPAT, WIN_PLUS} snd_window_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  read_target;
    logic [7:0]  local_data;
    logic [19:0] flash_addr;
    logic        flash_write;
    logic [7:0]  sound_addr;
    logic        sound_write;
    logic        sound_mode_write;
    logic        sound_plus_mode;

    // Mapper registers as the bench predicts them.
    logic [7:0]  mode_byte;
    logic [6:0]  bank_base;
    logic [7:0]  slot_sel;
    logic [7:0]  bank_regs [16];
    logic [7:0]  snd_mode_byte;
    logic [7:0]  snd_bank_regs [4];

    cbm_pkg::cbm_result_t pending_results [$];
    int unsigned mismatch_count = 0;
    bit          send_gaps_on   = 1'b1;
    bit          recv_stalls_on = 1'b1;

    cartridge_bank_mapper_core u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [1:0] slot_of(logic [15:0] a);
        if (mode_byte[4])
            return slot_sel[{a[15:14], 1'b0} +: 2];
        return 2'd0;
    endfunction

    function automatic logic [19:0] flash_offset(logic [15:0] a);
        logic [1:0]  s;
        logic [2:0]  page;
        logic [31:0] bank;
        logic [31:0] byte_addr;
        s = slot_of(a);
        if (mode_byte[7:6] == 2'b01)
        begin
            bank = bank_regs[{s, a[15:14]}] + bank_base;
            byte_addr = bank * 32'h4000 + a[13:0];
        end
        else
        begin
            // In 8 kB layout only 0x4000..0xBFFF carries a bank number.
            if (a[15:13] < 3'd2 || a[15:13] > 3'd5)
                return 20'd0;
            page = a[15:13] - 3'd2;
            bank = bank_regs[{s, page[1:0]}] + bank_base;
            byte_addr = bank * 32'h2000 + a[12:0];
        end
        byte_addr = byte_addr + 32'h40000 * s;
        return byte_addr[19:0];
    endfunction

    function automatic snd_window_t snd_window_now();
        if (snd_mode_byte[5] && snd_bank_regs[3][7])
            return WIN_PLUS;
        if (!snd_mode_byte[5] && snd_bank_regs[2][5:0] == 6'h3F)
            return WIN_COMPAT;
        return WIN_OFF;
    endfunction

    function automatic bit in_snd_window(snd_window_t w, logic [15:0] a);
        return (w == WIN_COMPAT && a >= 16'h9800 && a < 16'hA000) ||
               (w == WIN_PLUS && a >= 16'hB800 && a < 16'hC000);
    endfunction

    function automatic bit flash_decoded(logic [15:0] a);
        return mode_byte[7:6] == 2'b01 || (a >= 16'h4000 && a < 16'hC000);
    endfunction

    function automatic void apply_bank_write(logic [15:0] a, logic [7:0] v);
        logic [1:0] s;
        logic [2:0] page;
        logic [7:0] keep;
        s = slot_of(a);
        page = a[15:13] - 3'd2;
        if (mode_byte[1] || page > 3'd3)
            return;
        case (mode_byte[7:5])
            cbm_pkg::MAP_SOUND_8K:
            begin
                if (a[12:11] == 2'b10)
                begin
                    snd_bank_regs[page[1:0]] = v;
                    if (v[7] && page == 3'd0)
                        bank_base = v[6:0];
                    else
                    begin
                        keep = mode_byte[0] ? 8'h3F : 8'h7F;
                        bank_regs[{s, page[1:0]}] = v & keep;
                    end
                end
            end
            cbm_pkg::MAP_SPLIT_8K:
            begin
                // The low half takes bank numbers only at 0x5000..0x57FF, and
                // not at all when bit 3 is set.
                if ((a >= 16'h5000 && a < 16'h5800 && !mode_byte[3]) || a >= 16'h6000)
                begin
                    keep = mode_byte[0] ? 8'h1F : 8'h7F;
                    bank_regs[{s, page[1:0]}] = v & keep;
                end
            end
            cbm_pkg::MAP_DIRECT_A, cbm_pkg::MAP_DIRECT_B:
                bank_regs[{s, page[1:0]}] = v;
            cbm_pkg::MAP_WIN_2K_A, cbm_pkg::MAP_WIN_2K_B:
            begin
                if (a >= 16'h6000 && a < 16'h8000)
                    bank_regs[{s, a[12:11]}] = v;
            end
            cbm_pkg::MAP_PAIR_A, cbm_pkg::MAP_PAIR_B:
            begin
                // A 16 kB bank is two 8 kB banks; the doubling wraps in 8 bits.
                if (a >= 16'h6000 && a < 16'h6800)
                begin
                    bank_regs[{s, 2'd0}] = {v[6:0], 1'b0};
                    bank_regs[{s, 2'd1}] = {v[6:0], 1'b1};
                end
                if (a >= 16'h7000 && a < 16'h7800)
                begin
                    bank_regs[{s, 2'd2}] = {v[6:0], 1'b0};
                    bank_regs[{s, 2'd3}] = {v[6:0], 1'b1};
                end
            end
        endcase
    endfunction

    function automatic cbm_pkg::cbm_result_t mapper_access(logic kind, logic [15:0] a,
                                                           logic [7:0] v);
        cbm_pkg::cbm_result_t r;
        logic [19:0] pre_write_addr;
        snd_window_t win;
        bit          ram_lo;
        bit          ram_hi;
        r = '0;
        if (kind == cbm_pkg::REQ_READ)
        begin
            if (mode_byte[4] && a == 16'hFFFF)
            begin
                r.read_target = cbm_pkg::TGT_SUBSLOT;
                r.local_data  = ~slot_sel;
            end
            else if (mode_byte[7:5] == cbm_pkg::MAP_SOUND_8K &&
                     in_snd_window(snd_window_now(), a))
            begin
                r.read_target = cbm_pkg::TGT_SOUND;
                r.sound_addr  = a[7:0];
            end
            else if (flash_decoded(a))
            begin
                r.read_target = cbm_pkg::TGT_FLASH;
                r.flash_addr  = flash_offset(a);
            end
            else
            begin
                r.read_target = cbm_pkg::TGT_UNMAPPED;
                r.local_data  = 8'hFF;
            end
        end
        else
        begin
            // The flash sees the bank layout from before this write.
            pre_write_addr = flash_offset(a);
            if (mode_byte[4] && a == 16'hFFFF)
                slot_sel = v;
            if (!mode_byte[2] && a[15:1] == 15'h3FFF)
                mode_byte = v;
            if (mode_byte[7:5] == cbm_pkg::MAP_SOUND_8K)
            begin
                if (a[15:1] == 15'h5FFF)
                begin
                    snd_mode_byte = v;
                    r.sound_mode_write = 1'b1;
                end
                win = snd_window_now();
                ram_hi = snd_mode_byte[4];
                ram_lo = (snd_mode_byte[5] && snd_mode_byte[2]) || ram_hi;
                if ((win == WIN_COMPAT && !ram_lo && in_snd_window(WIN_COMPAT, a)) ||
                    (win == WIN_PLUS && !ram_hi && in_snd_window(WIN_PLUS, a)))
                begin
                    r.sound_write = 1'b1;
                    r.sound_addr  = a[7:0];
                end
            end
            apply_bank_write(a, v);
            if (flash_decoded(a))
            begin
                r.flash_write = 1'b1;
                r.flash_addr  = pre_write_addr;
            end
        end
        r.sound_plus_mode = snd_mode_byte[5];
        return r;
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_access(logic kind, logic [15:0] a, logic [7:0] v);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 16) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid  <= 1'b1;
        req_type   <= kind;
        address    <= a;
        write_data <= v;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(mapper_access(kind, a, v));
    endtask

    initial
    begin : response_side
        int                   hold;
        cbm_pkg::cbm_result_t want;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = recv_stalls_on ? $urandom_range(0, 16) : 0;
            repeat (hold)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (pending_results.size() == 0)
            begin
                $error("result item arrived with none outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_target", want.read_target, read_target);
                check_field("local_data", want.local_data, local_data);
                check_field("flash_addr", want.flash_addr, flash_addr);
                check_field("flash_write", want.flash_write, flash_write);
                check_field("sound_addr", want.sound_addr, sound_addr);
                check_field("sound_write", want.sound_write, sound_write);
                check_field("sound_mode_write", want.sound_mode_write, sound_mode_write);
                check_field("sound_plus_mode", want.sound_plus_mode, sound_plus_mode);
            end
        end
    end

    task automatic test_reset_decode();
        send_access(cbm_pkg::REQ_READ, 16'h0000, 8'h00);
        send_access(cbm_pkg::REQ_READ, 16'h4000, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 16'hBFFF, 8'h00);
        send_access(cbm_pkg::REQ_READ, 16'hC000, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 16'hFFFF, 8'h00);
    endtask

    task automatic test_sound_chip();
        // 0x3F in bank 2 opens the compat window, bank 3 bit 7 the extended one.
        send_access(cbm_pkg::REQ_WRITE, 16'h9000, 8'h3F);
        send_access(cbm_pkg::REQ_READ, 16'h9800, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 16'h9FFF, 8'hA5);
        send_access(cbm_pkg::REQ_WRITE, 16'hBFFE, 8'h20);
        send_access(cbm_pkg::REQ_WRITE, 16'hB7FF, 8'h80);
        send_access(cbm_pkg::REQ_READ, 16'hBFFF, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 16'hBFFF, 8'h00);
    endtask

    task automatic test_bank_offset();
        send_access(cbm_pkg::REQ_WRITE, 16'h5000, 8'h85);
        send_access(cbm_pkg::REQ_READ, 16'h7FFF, 8'h00);
    endtask

    task automatic test_pair_doubling();
        send_access(cbm_pkg::REQ_WRITE, 16'h7FFE, {cbm_pkg::MAP_PAIR_B, 5'b00000});
        send_access(cbm_pkg::REQ_WRITE, 16'h6000, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 16'h5FFF, 8'h00);
    endtask

    task automatic test_slot_select_16k();
        // 16 kB banks with subslots: the top page maps into subslot 3.
        send_access(cbm_pkg::REQ_WRITE, 16'h7FFF, {cbm_pkg::MAP_DIRECT_A, 5'b10000});
        send_access(cbm_pkg::REQ_WRITE, 16'hFFFF, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 16'hFFFF, 8'h00);
        send_access(cbm_pkg::REQ_READ, 16'hC000, 8'h00);
    endtask

    task automatic test_bank_write_disable();
        send_access(cbm_pkg::REQ_WRITE, 16'h7FFE, {cbm_pkg::MAP_SOUND_8K, 5'b00010});
        send_access(cbm_pkg::REQ_WRITE, 16'h5000, 8'h11);
        send_access(cbm_pkg::REQ_READ, 16'h4000, 8'h00);
    endtask

    task automatic random_access();
        int          pick;
        logic        kind;
        logic [15:0] a;
        logic [7:0]  v;
        pick = $urandom_range(0, 99);
        kind = cbm_pkg::REQ_WRITE;
        a = 16'($urandom);
        v = 8'($urandom);
        if (pick < 30)
            a[15:13] = 3'($urandom_range(2, 5));
        else if (pick < 40)
        begin
            case ($urandom_range(0, 2))
                0: a = 16'hBFFE | 16'($urandom_range(0, 1));
                1:
                begin
                    a = 16'h9000 | 16'($urandom_range(0, 16'h7FF));
                    if ($urandom_range(0, 1))
                        v = v | 8'h3F;
                end
                default: a = 16'hB000 | 16'($urandom_range(0, 16'h7FF));
            endcase
        end
        else if (pick < 45)
            a = 16'hFFFF;
        else if (pick < 80)
        begin
            kind = cbm_pkg::REQ_READ;
            case ($urandom_range(0, 3))
                0: a = 16'h9800 | 16'($urandom_range(0, 16'h7FF));
                1: a = 16'hB800 | 16'($urandom_range(0, 16'h7FF));
                2: a = 16'hFFFF;
                default: ;
            endcase
        end
        else if (pick < 90)
            a = ($urandom_range(0, 1) ? 16'h9800 : 16'hB800) | 16'($urandom_range(0, 16'h7FF));
        else
            kind = 1'($urandom);
        // Keep the mode register unlocked for the phases that follow.
        if (kind == cbm_pkg::REQ_WRITE && a[15:1] == 15'h3FFF)
            v[2] = 1'b0;
        send_access(kind, a, v);
    endtask

    task automatic test_random_phases();
        logic [2:0] map_mode;
        logic [4:0] mode_bits;
        for (int phase = 0; phase < 12; phase++)
        begin
            send_gaps_on   = phase[0];
            recv_stalls_on = phase[1];
            if (phase < 8)
                map_mode = 3'(phase);
            else if (phase == 8)
                map_mode = cbm_pkg::MAP_SOUND_8K;
            else
                map_mode = 3'($urandom_range(0, 7));
            mode_bits = 5'($urandom);
            mode_bits[2] = 1'b0;
            if ($urandom_range(0, 5) != 0)
                mode_bits[1] = 1'b0;
            if (phase == 7)
                mode_bits = 5'b11011;
            send_access(cbm_pkg::REQ_WRITE, 16'h7FFE | 16'($urandom_range(0, 1)),
                        {map_mode, mode_bits});
            repeat (84) random_access();
        end
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
    endtask

    task automatic test_mode_lock();
        // Once bit 2 is set the mode register ignores further writes.
        send_access(cbm_pkg::REQ_WRITE, 16'h7FFF, {cbm_pkg::MAP_SOUND_8K, 5'b00100});
        send_access(cbm_pkg::REQ_WRITE, 16'h7FFE, {cbm_pkg::MAP_PAIR_B, 5'b00000});
        send_access(cbm_pkg::REQ_WRITE, 16'h5000, 8'h83);
        send_access(cbm_pkg::REQ_READ, 16'h4000, 8'h00);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_type      = cbm_pkg::REQ_READ;
        address       = 16'h0000;
        write_data    = 8'h00;
        mode_byte     = 8'h00;
        bank_base     = 7'h00;
        slot_sel      = 8'h00;
        snd_mode_byte = 8'h00;
        foreach (bank_regs[i])
            bank_regs[i] = 8'h00;
        foreach (snd_bank_regs[i])
            snd_bank_regs[i] = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_decode();
        test_sound_chip();
        test_bank_offset();
        test_pair_doubling();
        test_slot_select_16k();
        test_bank_write_disable();
        test_random_phases();
        test_mode_lock();

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
